// ----- rtl/core/bfha_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bfha_pkg;
  localparam int MaxBlocks   = 64;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = IdxW + 1;
  localparam int ArenaBytes  = 65536;
  localparam int HeaderBytes = 40;
  localparam int SizeW       = 17;
  localparam int NeedW       = SizeW + 1;
  localparam int OffW        = 16;
  localparam int StampW      = 32;
  localparam int WideW       = 19;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OOM     = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_HEAP_BYTES = 1'b0;
  localparam logic CFG_MIN_SPLIT  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [SizeW-1:0] request_bytes;
    logic [OffW-1:0]  free_address;
  } in_item_t;

  typedef struct packed {
    logic [OffW-1:0] data_address;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic [OffW-1:0]   offset;
    logic [SizeW-1:0]  size;
    logic              free;
    logic [StampW-1:0] stamp;
  } entry_t;
endpackage
`default_nettype wire

// ----- rtl/core/best_fit_heap_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Best-fit heap allocator with coalescing over a bump arena.
// An input transfer carries an allocate (opcode 0, request_bytes) or a free
// (opcode 1, free_address). Each item yields exactly one result transfer with
// data_address and status (0 ok, 1 out of memory, 2 unknown address, 3 table
// full). The block table lives in a single-port-read memory, and a small
// sequencer walks it one entry per cycle; every scan reads entry i from the
// registered read port and compares it in the next cycle against one shared
// compare path. An allocate takes one table scan and a decision step, plus
// a parent write when a block is split; a free takes up to three table
// scans (owner, right neighbour, left neighbour) plus update steps. The
// block takes one item at a time, so a new item is accepted only after the
// result has been taken.
// The result sits in an output register; while out_stall is high it holds,
// and in_stall stays high until the result has been taken.
// Reset (synchronous, rst_n low) empties the table, the arena and the stamp
// counter and restores heap_bytes to 65536 and min_split_bytes to 64. The
// table contents need no clearing since only entries below the count are read.
// Configuration writes are always ready and are meant for times when no item
// is in flight.
module best_fit_heap_allocator_unit
  import bfha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [SizeW-1:0] cfg_data
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SCAN  = 11'b00000000010,
    S_ADEC  = 11'b00000000100,
    S_RDB   = 11'b00000001000,
    S_RDW   = 11'b00000010000,
    S_FRMK  = 11'b00000100000,
    S_MOVE  = 11'b00001000000,
    S_MOVW  = 11'b00010000000,
    S_LDEC  = 11'b00100000000,
    S_MERGE = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    SC_BEST  = 2'd0,
    SC_OWNER = 2'd1,
    SC_RIGHT = 2'd2,
    SC_LEFT  = 2'd3
  } scan_t;

  state_t            state_r, state_nxt;
  scan_t             scan_r;
  logic [CntW-1:0]   count_r;
  logic [SizeW-1:0]  top_r;
  logic [StampW-1:0] stamp_cnt_r;
  logic [SizeW-1:0]  heap_r, split_r;
  in_item_t          item_r;
  out_item_t         out_r;
  logic              out_valid_r;

  logic [CntW-1:0]   rd_ptr_r;   // next index to issue
  logic [CntW-1:0]   cmp_ptr_r;  // index of entry now in rd_data
  logic              cmp_v_r;

  logic              found_r;
  logic [IdxW-1:0]   best_r;
  entry_t            best_e_r;
  logic [IdxW-1:0]   b_r;        // freed block index
  entry_t            b_e_r;
  logic [IdxW-1:0]   hit_r;      // neighbor index
  entry_t            hit_e_r;
  logic [NeedW-1:0]  need_r;
  // Move of last entry into a hole.
  logic [IdxW-1:0]   hole_r;
  logic              after_right_r;

  logic              wr_en;
  logic [IdxW-1:0]   wr_idx, rd_idx;
  entry_t            wr_data, rd_data;

  bfha_table u_table (
    .clk(clk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
    .rd_idx(rd_idx), .rd_data(rd_data)
  );

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Shared compare path on the entry read out this cycle.
  logic [WideW-1:0] e_end, b_end;
  logic             match;
  always_comb begin
    e_end = WideW'(rd_data.offset) + WideW'(HeaderBytes) + WideW'(rd_data.size);
    b_end = WideW'(b_e_r.offset) + WideW'(HeaderBytes) + WideW'(b_e_r.size);
    match = 1'b0;
    case (scan_r)
      SC_BEST: match = rd_data.free && ({1'b0, rd_data.size} >= need_r) &&
                       (!found_r || rd_data.size < best_e_r.size ||
                        (rd_data.size == best_e_r.size &&
                         rd_data.stamp > best_e_r.stamp));
      SC_OWNER: match = !rd_data.free &&
                        (WideW'(rd_data.offset) + WideW'(HeaderBytes) ==
                         WideW'(item_r.free_address));
      SC_RIGHT: match = (cmp_ptr_r[IdxW-1:0] != b_r) && rd_data.free &&
                        (WideW'(rd_data.offset) == b_end);
      SC_LEFT: match = (cmp_ptr_r[IdxW-1:0] != b_r) && rd_data.free &&
                       (e_end == WideW'(b_e_r.offset));
      default: match = 1'b0;
    endcase
  end

  // Allocation decision arithmetic.
  logic [WideW-1:0] left_w, bump_end, limit_w;
  logic             do_split;
  always_comb begin
    left_w   = WideW'(best_e_r.size) - WideW'(need_r);
    limit_w  = (heap_r < SizeW'(ArenaBytes)) ? WideW'(heap_r) : WideW'(ArenaBytes);
    bump_end = WideW'(top_r) + WideW'(HeaderBytes) + WideW'(need_r);
    do_split = (left_w >= WideW'(split_r)) && (left_w >= WideW'(HeaderBytes)) &&
               (count_r < CntW'(MaxBlocks));
  end

  logic scan_done;
  assign scan_done = (rd_ptr_r >= count_r) && !cmp_v_r;

  always_comb begin
    rd_idx  = rd_ptr_r[IdxW-1:0];
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = rd_data;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && !out_valid_r) state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          case (scan_r)
            SC_BEST:  state_nxt = S_ADEC;
            SC_OWNER: state_nxt = found_r ? S_FRMK : S_OUT;
            SC_RIGHT: state_nxt = found_r ? S_RDB : S_SCAN;
            default:  state_nxt = found_r ? S_LDEC : S_OUT;
          endcase
        end
      end
      S_ADEC: begin
        state_nxt = S_OUT;
        if (found_r) begin
          wr_en = 1'b1;
          if (do_split) begin
            wr_idx = count_r[IdxW-1:0];
            wr_data.offset = OffW'(WideW'(best_e_r.offset) + WideW'(HeaderBytes) +
                                   WideW'(need_r));
            wr_data.size   = SizeW'(left_w - WideW'(HeaderBytes));
            wr_data.free   = 1'b1;
            wr_data.stamp  = best_e_r.stamp;
            state_nxt = S_RDB;  // then write the parent
          end else begin
            wr_idx = best_r;
            wr_data = best_e_r;
            wr_data.free = 1'b0;
          end
        end else if (bump_end <= limit_w && count_r < CntW'(MaxBlocks)) begin
          wr_en = 1'b1;
          wr_idx = count_r[IdxW-1:0];
          wr_data.offset = top_r[OffW-1:0];
          wr_data.size   = SizeW'(need_r);
          wr_data.free   = 1'b0;
          wr_data.stamp  = '0;
        end
      end
      S_RDB: begin
        if (scan_r == SC_BEST) begin
          wr_en = 1'b1;
          wr_idx = best_r;
          wr_data = best_e_r;
          wr_data.size = SizeW'(need_r);
          wr_data.free = 1'b0;
          state_nxt = S_OUT;
        end else begin
          // Right merge: grow b, then move last entry into hit's slot.
          wr_en = 1'b1;
          wr_idx = b_r;
          wr_data = b_e_r;
          wr_data.size = SizeW'(WideW'(b_e_r.size) + WideW'(HeaderBytes) +
                                WideW'(hit_e_r.size));
          rd_idx = IdxW'(count_r - 1'b1);
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        // Read the last entry after the grown block has been written.
        rd_idx = IdxW'(count_r - 1'b1);
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        wr_en = 1'b1;
        wr_idx = hole_r;
        wr_data = rd_data;
        state_nxt = after_right_r ? S_SCAN : S_OUT;
      end
      S_FRMK: begin
        wr_en = 1'b1;
        wr_idx = b_r;
        wr_data = b_e_r;
        wr_data.free = 1'b1;
        wr_data.stamp = stamp_cnt_r + 1'b1;
        state_nxt = S_SCAN;
      end
      S_LDEC: begin
        wr_en = 1'b1;
        wr_idx = hit_r;
        wr_data = hit_e_r;
        wr_data.size = SizeW'(WideW'(hit_e_r.size) + WideW'(HeaderBytes) +
                              WideW'(b_e_r.size));
        rd_idx = IdxW'(count_r - 1'b1);
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        rd_idx = IdxW'(count_r - 1'b1);
        state_nxt = S_MOVE;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      top_r <= '0;
      stamp_cnt_r <= '0;
      heap_r <= SizeW'(65536);
      split_r <= SizeW'(64);
      out_valid_r <= 1'b0;
      cmp_v_r <= 1'b0;
      found_r <= 1'b0;
      scan_r <= SC_BEST;
      rd_ptr_r <= '0;
      cmp_ptr_r <= '0;
      after_right_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_HEAP_BYTES) heap_r <= cfg_data;
        else split_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !out_valid_r) begin
            item_r <= in_data;
            need_r <= NeedW'((WideW'(in_data.request_bytes) + WideW'(7)) &
                             ~WideW'(7));
            found_r <= 1'b0;
            rd_ptr_r <= '0;
            cmp_v_r <= 1'b0;
            out_r <= '{data_address: '0, status: STATUS_OK};
            if (in_data.opcode == OP_ALLOC) begin
              scan_r <= SC_BEST;
            end else begin
              scan_r <= SC_OWNER;
              if (in_data.free_address < OffW'(HeaderBytes)) begin
                rd_ptr_r <= count_r;  // empty scan: unknown address
              end
            end
          end
        end
        S_SCAN: begin
          cmp_v_r <= (rd_ptr_r < count_r);
          cmp_ptr_r <= rd_ptr_r;
          if (rd_ptr_r < count_r) rd_ptr_r <= rd_ptr_r + 1'b1;
          if (cmp_v_r && match) begin
            found_r <= 1'b1;
            if (scan_r == SC_BEST) begin
              best_r <= cmp_ptr_r[IdxW-1:0];
              best_e_r <= rd_data;
            end else if (scan_r == SC_OWNER) begin
              b_r <= cmp_ptr_r[IdxW-1:0];
              b_e_r <= rd_data;
            end else begin
              hit_r <= cmp_ptr_r[IdxW-1:0];
              hit_e_r <= rd_data;
            end
            // First hit ends the scan for the free passes.
            if (scan_r != SC_BEST) begin
              rd_ptr_r <= count_r;
              cmp_v_r <= 1'b0;
            end
          end
          if (scan_done) begin
            case (scan_r)
              SC_OWNER: if (!found_r) out_r.status <= STATUS_UNKNOWN;
              SC_RIGHT: if (!found_r) begin
                scan_r <= SC_LEFT;
                rd_ptr_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_ADEC: begin
          if (found_r) begin
            out_r.data_address <= OffW'(WideW'(best_e_r.offset) +
                                        WideW'(HeaderBytes));
            if (do_split) count_r <= count_r + 1'b1;
          end else if (bump_end > limit_w) begin
            out_r.status <= STATUS_OOM;
          end else if (count_r >= CntW'(MaxBlocks)) begin
            out_r.status <= STATUS_FULL;
          end else begin
            out_r.data_address <= OffW'(WideW'(top_r) + WideW'(HeaderBytes));
            count_r <= count_r + 1'b1;
            top_r <= SizeW'(bump_end);
          end
        end
        S_FRMK: begin
          stamp_cnt_r <= stamp_cnt_r + 1'b1;
          b_e_r.free <= 1'b1;
          b_e_r.stamp <= stamp_cnt_r + 1'b1;
          scan_r <= SC_RIGHT;
          found_r <= 1'b0;
          rd_ptr_r <= '0;
          cmp_v_r <= 1'b0;
        end
        S_RDB: begin
          if (scan_r != SC_BEST) begin
            b_e_r.size <= SizeW'(WideW'(b_e_r.size) + WideW'(HeaderBytes) +
                                 WideW'(hit_e_r.size));
            if (b_r == IdxW'(count_r - 1'b1)) b_r <= hit_r;
            hole_r <= hit_r;
            after_right_r <= 1'b1;
          end
        end
        S_MOVE: begin
          count_r <= count_r - 1'b1;
          if (after_right_r) begin
            scan_r <= SC_LEFT;
            found_r <= 1'b0;
            rd_ptr_r <= '0;
            cmp_v_r <= 1'b0;
          end
        end
        S_LDEC: begin
          hole_r <= b_r;
          after_right_r <= 1'b0;
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // A result is never offered while the table is in a merge or move state.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE || state_r == S_SCAN ||
                     state_r == S_ADEC || state_r == S_OUT ||
                     state_r == S_FRMK))
    else $error("result valid in move state");
  // The table never holds more entries than it has room for.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxBlocks))
    else $error("entry count overflow");
  // The arena top never passes the arena size.
  a_top: assert property (@(posedge clk) disable iff (!rst_n)
    WideW'(top_r) <= WideW'(ArenaBytes))
    else $error("arena top overflow");
endmodule
`default_nettype wire

// ----- rtl/core/bfha_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Block table memory: one write port, one registered read port.
module bfha_table
  import bfha_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IdxW-1:0] wr_idx,
  input  entry_t               wr_data,
  input  wire logic [IdxW-1:0] rd_idx,
  output entry_t               rd_data
);
  entry_t mem [MaxBlocks];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end
endmodule
`default_nettype wire
